// ----- hdl/tetpd_pkg.sv -----
`default_nettype none
package tetpd_pkg;
    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } t_in;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] count;
    } t_out;

    localparam logic [1:0] OUT_INSIDE    = 2'd0;
    localparam logic [1:0] OUT_ESCAPED   = 2'd1;
    localparam logic [1:0] OUT_PERIODIC  = 2'd2;
    localparam logic [1:0] OUT_UNDECIDED = 2'd3;

    localparam logic [1:0] CFG_MAX_ITER   = 2'd0;
    localparam logic [1:0] CFG_MAX_PERIOD = 2'd1;
    localparam logic [1:0] CFG_EPS_SQ     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DISC, S_INIT, S_SQ, S_CHK, S_P1, S_P2, S_P3, S_UPD,
        S_SCAN, S_SD, S_SQD, S_SCMP, S_DONE
    } t_state;

    // multiplier operand select
    typedef enum logic [3:0] {
        M_RR, M_II, M_AR, M_BI, M_AI, M_BR, M_RI, M_DD, M_DI
    } t_msel;

    typedef struct packed {
        logic       init;
        logic       mul_go;
        t_msel      msel;
        logic       upd;
        logic       sq_latch;
        logic       scan_load;
        logic       diff;
        logic       set_res;
        logic [1:0] res_code;
        logic       res_use_idx;
    } t_cmd;

    typedef struct packed {
        logic in_disc;
        logic cont;
        logic last_iter;
        logic scan_more;
        logic match;
        logic mul_done;
    } t_sts;
endpackage
`default_nettype wire

// ----- hdl/tricorn_escape_time_period_detect.sv -----
`default_nettype none
// Tricorn escape-time classifier with a periodicity check. Raise start with
// a point while busy is low; exactly one result word follows, shown on
// o_res for a single cycle with o_valid high, and it must be captured then:
// there is no way to hold it. One point at a time. Cost per point is set by
// the single shared 48x48 multiplier (four 24x24 partial products each):
// seven products per orbit step plus a check state and an update state. A
// point that reaches the iteration limit then scans the stored orbit points
// for a period match. Points inside the unit disc skip the orbit: the disc
// test sets their result directly. Configuration should be written only
// while idle.
module tricorn_escape_time_period_detect #(
    parameter int MAX_PERIOD = 16,
    parameter int FRAC_BITS  = 28
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire tetpd_pkg::t_in i_in,
    output logic                o_valid,
    output tetpd_pkg::t_out     o_res,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_idx,
    input  wire [28:0]          i_cfg_data
);
    logic [15:0] r_max_iter;
    logic [4:0]  r_max_period;
    logic [28:0] r_eps_sq;
    tetpd_pkg::t_cmd w_cmd;
    tetpd_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= 16'd500;
            r_max_period <= 5'd10;
            r_eps_sq     <= 29'd26844;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tetpd_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[15:0];
                tetpd_pkg::CFG_MAX_PERIOD: r_max_period <= i_cfg_data[4:0];
                tetpd_pkg::CFG_EPS_SQ:     r_eps_sq     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tetpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid)
    );

    tetpd_dp #(.MAX_PERIOD(MAX_PERIOD), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_max_iter(r_max_iter), .i_max_period(r_max_period), .i_eps_sq(r_eps_sq),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_res(o_res)
    );
endmodule
`default_nettype wire

// ----- hdl/tetpd_ram.sv -----
`default_nettype none
module tetpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/tetpd_mul.sv -----
`default_nettype none
// 48x48 signed fixed multiply: 24-bit limbs, four partial products summed
// in turn, then round toward zero and saturate.
module tetpd_mul #(
    parameter int FRAC_BITS = 28
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_go,
    input  wire signed [47:0]  i_a,
    input  wire signed [47:0]  i_b,
    output logic signed [47:0] o_p,
    output logic               o_done
);
    logic        r_neg;
    logic [47:0] r_ua, r_ub;
    logic [95:0] r_acc;
    logic [2:0]  r_step;
    logic        r_busy;
    logic [23:0] w_x, w_y;
    logic [47:0] w_pp;
    logic [95:0] w_sh;
    logic [95:0] w_q;
    logic [47:0] w_mag;

    always_comb begin
        w_x = r_step[0] ? r_ua[47:24] : r_ua[23:0];
        w_y = r_step[1] ? r_ub[47:24] : r_ub[23:0];
        w_pp = w_x * w_y;
        w_sh = {48'd0, w_pp} << (24 * (32'(r_step[0]) + 32'(r_step[1])));
        w_q = r_acc >> FRAC_BITS;
        if (w_q > 96'h8000_0000_0000) w_mag = 48'h8000_0000_0000;
        else w_mag = w_q[47:0];
        if (r_neg) o_p = -w_mag;
        else if (w_mag[47]) o_p = 48'h7FFF_FFFF_FFFF;
        else o_p = w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_acc  <= '0;
                r_neg  <= i_a[47] ^ i_b[47];
                r_ua   <= i_a[47] ? -i_a : i_a;
                r_ub   <= i_b[47] ? -i_b : i_b;
            end else if (r_busy) begin
                r_acc <= r_acc + w_sh;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tetpd_dp.sv -----
`default_nettype none
module tetpd_dp #(
    parameter int MAX_PERIOD = 16,
    parameter int FRAC_BITS  = 28
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire tetpd_pkg::t_in i_in,
    input  wire [15:0]          i_max_iter,
    input  wire [4:0]           i_max_period,
    input  wire [28:0]          i_eps_sq,
    input  wire tetpd_pkg::t_cmd i_cmd,
    output tetpd_pkg::t_sts     o_sts,
    output tetpd_pkg::t_out     o_res
);
    localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int PW = $clog2(MAX_PERIOD + 1);
    localparam logic signed [49:0] LIM = 50'sd100 <<< FRAC_BITS;
    localparam logic signed [49:0] SHI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SLO = -50'sh0_8000_0000_0000;

    logic signed [47:0] r_are, r_aim, r_re, r_im, r_re2, r_im2;
    logic signed [47:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [47:0] r_dr, r_di;
    logic signed [47:0] r_eps;
    logic [15:0]        r_i;
    logic [PW-1:0]      r_eff, r_j;
    logic [63:0]        r_disc;
    tetpd_pkg::t_out    r_res;
    logic signed [47:0] w_ma, w_mb, w_p, w_ore, w_oim;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic               w_we;
    logic               w_mul_done;
    logic [16:0]        w_sum;
    logic signed [49:0] w_nre, w_nim, w_s, w_drx, w_dix, w_d;
    logic signed [47:0] w_are, w_aim;
    logic [31:0]        w_ucr, w_uci;
    logic [PW-1:0]      w_eff;

    function automatic logic signed [47:0] sat(input logic signed [49:0] v);
        if (v > SHI) sat = 48'sh7FFF_FFFF_FFFF;
        else if (v < SLO) sat = 48'sh8000_0000_0000;
        else sat = v[47:0];
    endfunction

    function automatic logic signed [47:0] from28(input logic signed [47:0] v);
        if (FRAC_BITS >= 28) from28 = v <<< (FRAC_BITS - 28);
        else from28 = v >>> (28 - FRAC_BITS);
    endfunction

    tetpd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.mul_go),
        .i_a(w_ma), .i_b(w_mb), .o_p(w_p), .o_done(w_mul_done)
    );

    always_comb begin
        case (i_cmd.msel)
            tetpd_pkg::M_RR: begin w_ma = r_re;  w_mb = r_re; end
            tetpd_pkg::M_II: begin w_ma = r_im;  w_mb = r_im; end
            tetpd_pkg::M_AR: begin w_ma = r_are; w_mb = r_re; end
            tetpd_pkg::M_BI: begin w_ma = r_aim; w_mb = r_im; end
            tetpd_pkg::M_AI: begin w_ma = r_are; w_mb = r_im; end
            tetpd_pkg::M_BR: begin w_ma = r_aim; w_mb = r_re; end
            tetpd_pkg::M_RI: begin w_ma = r_re;  w_mb = r_im; end
            tetpd_pkg::M_DD: begin w_ma = r_dr;  w_mb = r_dr; end
            tetpd_pkg::M_DI: begin w_ma = r_di;  w_mb = r_di; end
            default:         begin w_ma = '0;    w_mb = '0;   end
        endcase
    end

    // orbit write index i+eff-max, kept when in range
    always_comb begin
        w_sum = 17'(r_i) + 17'(r_eff);
        w_we = i_cmd.upd && (w_sum >= 17'(i_max_iter)) &&
               (w_sum - 17'(i_max_iter) < 17'(MAX_PERIOD));
        w_waddr = AW'(w_sum - 17'(i_max_iter));
        w_raddr = AW'(r_eff - r_j - PW'(1));
        w_nre = 50'(r_p0) + 50'(r_p1) + 50'(r_re2) - 50'(r_im2);
        w_nim = -50'(r_p2) + 50'(r_p3) - 50'(r_p4) - 50'(r_p4);
        w_s   = 50'(r_re2) + 50'(r_im2);
        w_drx = 50'(r_re) - 50'(w_ore);
        w_dix = 50'(r_im) - 50'(w_oim);
        w_d   = 50'(r_p0) + 50'(r_p1);
        w_are = from28(48'(i_in.c_re));
        w_aim = from28(48'(i_in.c_im));
        w_ucr = i_in.c_re[31] ? 32'(-i_in.c_re) : 32'(i_in.c_re);
        w_uci = i_in.c_im[31] ? 32'(-i_in.c_im) : 32'(i_in.c_im);
        w_eff = (32'(i_max_period) > MAX_PERIOD) ? PW'(MAX_PERIOD) : PW'(i_max_period);
        if (32'(w_eff) > 32'(i_max_iter)) w_eff = PW'(i_max_iter);
    end

    tetpd_ram #(.WIDTH(48), .DEPTH(MAX_PERIOD)) u_ore (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_re),
        .i_raddr(w_raddr), .o_rdata(w_ore)
    );
    tetpd_ram #(.WIDTH(48), .DEPTH(MAX_PERIOD)) u_oim (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_im),
        .i_raddr(w_raddr), .o_rdata(w_oim)
    );

    always_ff @(posedge i_clk) begin
        // disc test on the raw Q4.28 point, both squares taken at accept
        if (i_cmd.init) begin
            r_are <= w_are;
            r_aim <= w_aim;
            r_re  <= -(w_are / 2);
            r_im  <= w_aim / 2;
            r_i   <= '0;
            r_eff <= w_eff;
            r_j   <= '0;
            r_eps <= from28(48'(i_eps_sq));
            r_disc <= 64'(w_ucr) * 64'(w_ucr) + 64'(w_uci) * 64'(w_uci);
        end
        if (w_mul_done) begin
            case (i_cmd.msel)
                tetpd_pkg::M_RR: r_re2 <= w_p;
                tetpd_pkg::M_II: r_im2 <= w_p;
                tetpd_pkg::M_AR: r_p0 <= w_p;
                tetpd_pkg::M_BI: r_p1 <= w_p;
                tetpd_pkg::M_AI: r_p2 <= w_p;
                tetpd_pkg::M_BR: r_p3 <= w_p;
                tetpd_pkg::M_RI: r_p4 <= w_p;
                tetpd_pkg::M_DD: r_p0 <= w_p;
                tetpd_pkg::M_DI: r_p1 <= w_p;
                default: ;
            endcase
        end
        if (i_cmd.upd) begin
            r_re <= sat(w_nre);
            r_im <= sat(w_nim);
            r_i  <= r_i + 16'd1;
        end
        if (i_cmd.diff) begin
            r_dr <= sat(w_drx);
            r_di <= sat(w_dix);
        end
        if (i_cmd.scan_load) r_j <= r_j + PW'(1);
        if (i_cmd.set_res) begin
            r_res.outcome <= i_cmd.res_code;
            if (i_cmd.res_code == tetpd_pkg::OUT_ESCAPED) r_res.count <= r_i;
            else if (i_cmd.res_use_idx) r_res.count <= 16'(r_j);
            else r_res.count <= '0;
        end
    end

    assign o_res = r_res;
    always_comb begin
        o_sts.in_disc   = r_disc < 64'h0100_0000_0000_0000;
        o_sts.cont      = (r_i < i_max_iter) && (w_s < LIM);
        o_sts.last_iter = r_i >= i_max_iter;
        o_sts.scan_more = r_j < r_eff;
        o_sts.match     = w_d < 50'(r_eps);
        o_sts.mul_done  = w_mul_done;
    end
    // sq_latch is implied by mul_done; keep the command bit visible for tracing
    logic w_unused;
    assign w_unused = i_cmd.sq_latch;
endmodule
`default_nettype wire

// ----- hdl/tetpd_ctrl.sv -----
`default_nettype none
module tetpd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire tetpd_pkg::t_sts i_sts,
    output tetpd_pkg::t_cmd   o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    tetpd_pkg::t_state r_st, n_st;
    tetpd_pkg::t_msel  r_ms, n_ms;
    logic              r_go, n_go;

    // go is registered together with the select, so the operands match when go is seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tetpd_pkg::S_IDLE;
            r_ms <= tetpd_pkg::M_RR;
            r_go <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ms <= n_ms;
            r_go <= n_go;
        end
    end

    // next state; products step through the selects in order
    always_comb begin
        n_st = r_st;
        n_ms = r_ms;
        n_go = 1'b0;
        case (r_st)
            tetpd_pkg::S_IDLE: if (i_start) n_st = tetpd_pkg::S_DISC;
            tetpd_pkg::S_DISC: begin
                if (i_sts.in_disc) n_st = tetpd_pkg::S_DONE;
                else begin
                    n_st = tetpd_pkg::S_SQ; n_ms = tetpd_pkg::M_RR; n_go = 1'b1;
                end
            end
            tetpd_pkg::S_SQ: if (i_sts.mul_done) begin
                if (r_ms == tetpd_pkg::M_RR) begin
                    n_ms = tetpd_pkg::M_II; n_go = 1'b1;
                end else n_st = tetpd_pkg::S_CHK;
            end
            tetpd_pkg::S_CHK: begin
                if (i_sts.cont) begin
                    n_st = tetpd_pkg::S_P1; n_ms = tetpd_pkg::M_AR; n_go = 1'b1;
                end else if (!i_sts.last_iter) n_st = tetpd_pkg::S_DONE;
                else n_st = tetpd_pkg::S_SCAN;
            end
            tetpd_pkg::S_P1: if (i_sts.mul_done) begin
                n_go = 1'b1;
                case (r_ms)
                    tetpd_pkg::M_AR: n_ms = tetpd_pkg::M_BI;
                    tetpd_pkg::M_BI: n_ms = tetpd_pkg::M_AI;
                    tetpd_pkg::M_AI: n_ms = tetpd_pkg::M_BR;
                    tetpd_pkg::M_BR: n_ms = tetpd_pkg::M_RI;
                    default: begin n_go = 1'b0; n_st = tetpd_pkg::S_UPD; end
                endcase
            end
            tetpd_pkg::S_UPD: begin
                n_st = tetpd_pkg::S_SQ; n_ms = tetpd_pkg::M_RR; n_go = 1'b1;
            end
            tetpd_pkg::S_SCAN: begin
                if (i_sts.scan_more) n_st = tetpd_pkg::S_SD;
                else n_st = tetpd_pkg::S_DONE;
            end
            tetpd_pkg::S_SD: begin
                n_st = tetpd_pkg::S_SQD; n_ms = tetpd_pkg::M_DD; n_go = 1'b1;
            end
            tetpd_pkg::S_SQD: if (i_sts.mul_done) begin
                if (r_ms == tetpd_pkg::M_DD) begin
                    n_ms = tetpd_pkg::M_DI; n_go = 1'b1;
                end else n_st = tetpd_pkg::S_SCMP;
            end
            tetpd_pkg::S_SCMP: begin
                if (i_sts.match) n_st = tetpd_pkg::S_DONE;
                else n_st = tetpd_pkg::S_SCAN;
            end
            tetpd_pkg::S_DONE: n_st = tetpd_pkg::S_IDLE;
            default: n_st = tetpd_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.msel = r_ms;
        o_cmd.mul_go = r_go;
        o_cmd.init = (r_st == tetpd_pkg::S_IDLE);
        o_cmd.sq_latch = (r_st == tetpd_pkg::S_SQ);
        o_cmd.upd = (r_st == tetpd_pkg::S_UPD);
        o_cmd.diff = (r_st == tetpd_pkg::S_SD);
        o_cmd.scan_load = (r_st == tetpd_pkg::S_SCMP) && !i_sts.match;
        o_busy = (r_st != tetpd_pkg::S_IDLE);
        o_done = (r_st == tetpd_pkg::S_DONE);
        case (r_st)
            tetpd_pkg::S_DISC: if (i_sts.in_disc) begin
                o_cmd.set_res = 1'b1; o_cmd.res_code = tetpd_pkg::OUT_INSIDE;
            end
            tetpd_pkg::S_CHK: if (!i_sts.cont) begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_code = i_sts.last_iter ? tetpd_pkg::OUT_UNDECIDED
                                                 : tetpd_pkg::OUT_ESCAPED;
            end
            tetpd_pkg::S_SCMP: if (i_sts.match) begin
                o_cmd.set_res = 1'b1; o_cmd.res_code = tetpd_pkg::OUT_PERIODIC;
                o_cmd.res_use_idx = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
